// ----- rtl/ecc_pkg.sv -----
// shared constants, types and calendar tables of the epoch seconds calendar converter
package ecc_pkg;

    // pipeline depth, one register stage per entry
    localparam int unsigned NUM_STAGES = 7;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    // calendar limits
    localparam int unsigned BASE_YEAR     = 2000;
    localparam int unsigned YEAR_LAST     = 2099;
    localparam int unsigned MONTHS        = 12;
    localparam int unsigned HOURS         = 24;
    localparam int unsigned MINUTES       = 60;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam logic [31:0] MAX_ELAPSED   = 32'd3155759999;

    // seconds per day = 675 * 2^7, divide the upper bits by 675
    localparam int unsigned DAY_SHIFT        = 7;
    localparam int unsigned DAY_ODD          = 675;
    localparam int unsigned DAY_RECIP_SHIFT  = 35;
    localparam logic [25:0] DAY_RECIP        = 26'((64'd1 << DAY_RECIP_SHIFT) / DAY_ODD);

    // seconds per hour = 225 * 2^4
    localparam int unsigned HOUR_SHIFT       = 4;
    localparam int unsigned HOUR_ODD         = 225;
    localparam int unsigned HOUR_RECIP_SHIFT = 24;
    localparam logic [16:0] HOUR_RECIP       = 17'((64'd1 << HOUR_RECIP_SHIFT) / HOUR_ODD);

    // seconds per minute = 15 * 2^2
    localparam int unsigned MIN_SHIFT        = 2;
    localparam int unsigned MIN_ODD          = 15;
    localparam int unsigned MIN_RECIP_SHIFT  = 16;
    localparam logic [12:0] MIN_RECIP        = 13'((64'd1 << MIN_RECIP_SHIFT) / MIN_ODD);

    // days per year estimate
    localparam int unsigned YEAR_RECIP_SHIFT = 24;
    localparam logic [15:0] YEAR_RECIP       = 16'((64'd1 << YEAR_RECIP_SHIFT) / DAYS_PER_YEAR);

    // days before month index idx (0 = january), leap years add one from march on
    function automatic logic [8:0] cum_month(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        logic       extra;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            4'd12:   base = 9'd365;
            default: base = 9'd0;
        endcase
        extra = leap && (idx >= 4'd2) && (idx <= 4'd12);
        return base + {8'd0, extra};
    endfunction

    // days before year index yi; every fourth year from the base year is a leap year
    function automatic logic [15:0] cum_year(input logic [6:0] yi);
        logic [15:0] leaps;
        leaps = 16'(({1'b0, yi} + 8'd3) >> 2);
        return 16'(yi) * 16'(DAYS_PER_YEAR) + leaps;
    endfunction

endpackage

// ----- rtl/epoch_seconds_calendar_converter.sv -----
// top level of the epoch seconds calendar converter, pipeline control and output packing
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  s_tdata: calendar fields and elapsed, s_tuser: operation
//  m_*      out  m_tvalid / m_tready  m_tdata: elapsed and calendar fields, m_tuser: range_error
//
//  seven register stages, one word accepted per cycle unless every stage is full and the output stalls
//  the throughput is set by the stage chain; each divide by a constant is a
//  reciprocal multiply followed by a one step correction in the next stage
//  rst_n clears the stage valid bits only
//  a stage holds while it is full and the stage after it cannot take its word;
//  empty stages keep filling, so while a result waits the input stays open until every stage is full
module epoch_seconds_calendar_converter
    import ecc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // in_year[11:0], in_month[15:12], in_day[20:16], in_hour[25:21],
    // in_minute[31:26], in_second[37:32], in_elapsed[69:38], zero pad
    input  logic [71:0] s_tdata,
    // operation[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_elapsed[31:0], out_year[43:32], out_month[47:44], out_day[52:48],
    // out_hour[57:53], out_minute[63:58], out_second[69:64], zero pad
    output logic [71:0] m_tdata,
    // range_error[0]
    output logic [0:0]  m_tuser
);

    localparam int unsigned LAST = NUM_STAGES - 1;

    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [31:0] in_elapsed;
    logic        cal_bad;
    logic        range_err;

    stage_en_t              en;
    logic [NUM_STAGES-1:0]  valid_next, valid_reg;
    logic [NUM_STAGES-1:0]  op_reg, err_reg;
    logic [31:0]            elapsed_reg [2:LAST];

    logic [31:0] pack_elapsed;
    logic [15:0] days;
    logic [16:0] sod;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        ok_cal, ok_sec;

    // unpack the input word
    assign in_year    = s_tdata[11:0];
    assign in_month   = s_tdata[15:12];
    assign in_day     = s_tdata[20:16];
    assign in_hour    = s_tdata[25:21];
    assign in_minute  = s_tdata[31:26];
    assign in_second  = s_tdata[37:32];
    assign in_elapsed = s_tdata[69:38];

    // range check of the fields the operation uses
    always_comb
    begin
        cal_bad = (in_year < 12'(BASE_YEAR)) || (in_year > 12'(YEAR_LAST))
                  || (in_month == 4'd0) || (in_month > 4'(MONTHS))
                  || (in_day == 5'd0) || (in_hour >= 5'(HOURS))
                  || (in_minute >= 6'(MINUTES)) || (in_second >= 6'(MINUTES));
        range_err = s_tuser[0] ? (in_elapsed > MAX_ELAPSED) : cal_bad;
    end

    // stage enables: a stage loads when empty or when its word moves on
    always_comb
    begin
        en[LAST] = !valid_reg[LAST] || m_tready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // operation and error flag travel with the word
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            op_reg[0]  <= s_tuser[0];
            err_reg[0] <= range_err;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                op_reg[k]  <= op_reg[k-1];
                err_reg[k] <= err_reg[k-1];
            end
        end
    end

    // elapsed result of the calendar path, delayed to the output stage
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            elapsed_reg[2] <= pack_elapsed;
        end
        for (int k = 3; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                elapsed_reg[k] <= elapsed_reg[k-1];
            end
        end
    end

    ecc_date_pack u_date_pack (
        .clk       (clk),
        .en        (en),
        .in_year   (in_year),
        .in_month  (in_month),
        .in_day    (in_day),
        .in_hour   (in_hour),
        .in_minute (in_minute),
        .in_second (in_second),
        .elapsed   (pack_elapsed)
    );

    ecc_day_split u_day_split (
        .clk        (clk),
        .en         (en),
        .in_elapsed (in_elapsed),
        .days       (days),
        .sod        (sod)
    );

    ecc_time_split u_time_split (
        .clk    (clk),
        .en     (en),
        .sod    (sod),
        .hour   (hour),
        .minute (minute),
        .second (second)
    );

    ecc_date_split u_date_split (
        .clk   (clk),
        .en    (en),
        .days  (days),
        .year  (year),
        .month (month),
        .day   (day)
    );

    // output word: fields of the other operation and of a failed check read zero
    assign ok_cal = !op_reg[LAST] && !err_reg[LAST];
    assign ok_sec = op_reg[LAST] && !err_reg[LAST];

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[LAST];
    assign m_tuser  = err_reg[LAST];
    assign m_tdata  = {2'b00,
                       ok_sec ? second : 6'd0,
                       ok_sec ? minute : 6'd0,
                       ok_sec ? hour   : 5'd0,
                       ok_sec ? day    : 5'd0,
                       ok_sec ? month  : 4'd0,
                       ok_sec ? year   : 12'd0,
                       ok_cal ? elapsed_reg[LAST] : 32'd0};

endmodule

// ----- rtl/ecc_date_pack.sv -----
// calendar fields to elapsed seconds, two pipeline stages
module ecc_date_pack
    import ecc_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  logic [11:0] in_year,
    input  logic [3:0]  in_month,
    input  logic [4:0]  in_day,
    input  logic [4:0]  in_hour,
    input  logic [5:0]  in_minute,
    input  logic [5:0]  in_second,
    output logic [31:0] elapsed
);

    logic [6:0]  yi;
    logic        leap;
    logic [15:0] days_next, days_reg;
    logic [16:0] tod_next, tod_reg;
    logic [32:0] day_secs;
    logic [31:0] elapsed_next, elapsed_reg;

    // stage 0: day count from tables, seconds of the day
    always_comb
    begin
        yi        = 7'(in_year - 12'(BASE_YEAR));
        leap      = (yi[1:0] == 2'b00);
        days_next = cum_year(yi) + 16'(cum_month(leap, in_month - 4'd1))
                    + 16'(in_day - 5'd1);
        tod_next  = 17'(in_hour) * 17'(SECS_PER_HOUR) + 17'(in_minute) * 17'(SECS_PER_MIN)
                    + 17'(in_second);
    end

    // stage 1: scale days to seconds
    always_comb
    begin
        day_secs     = 33'(days_reg) * 33'(SECS_PER_DAY);
        elapsed_next = day_secs[31:0] + 32'(tod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            days_reg <= days_next;
            tod_reg  <= tod_next;
        end
        if (en[1])
        begin
            elapsed_reg <= elapsed_next;
        end
    end

    assign elapsed = elapsed_reg;

endmodule

// ----- rtl/ecc_day_split.sv -----
// elapsed seconds split into whole days and seconds of the day, three stages
module ecc_day_split
    import ecc_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  logic [31:0] in_elapsed,
    output logic [15:0] days,
    output logic [16:0] sod
);

    logic [24:0] hi0_reg, hi1_reg;
    logic [6:0]  lo0_reg, lo1_reg;
    logic [50:0] prod_next, prod_reg;
    logic [15:0] q0;
    logic [24:0] rem0;
    logic [15:0] days_next, days_reg;
    logic [16:0] sod_next, sod_reg;

    // stage 1: reciprocal multiply for the divide by 675
    assign prod_next = 51'(hi0_reg) * 51'(DAY_RECIP);

    // stage 2: quotient may be one short, fix it with the remainder
    always_comb
    begin
        q0   = prod_reg[50:DAY_RECIP_SHIFT];
        rem0 = hi1_reg - 25'(26'(q0) * 26'(DAY_ODD));
        if (rem0 >= 25'(DAY_ODD))
        begin
            days_next = q0 + 16'd1;
            sod_next  = {10'(rem0 - 25'(DAY_ODD)), lo1_reg};
        end
        else
        begin
            days_next = q0;
            sod_next  = {10'(rem0), lo1_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hi0_reg <= in_elapsed[31:DAY_SHIFT];
            lo0_reg <= in_elapsed[DAY_SHIFT-1:0];
        end
        if (en[1])
        begin
            prod_reg <= prod_next;
            hi1_reg  <= hi0_reg;
            lo1_reg  <= lo0_reg;
        end
        if (en[2])
        begin
            days_reg <= days_next;
            sod_reg  <= sod_next;
        end
    end

    assign days = days_reg;
    assign sod  = sod_reg;

endmodule

// ----- rtl/ecc_time_split.sv -----
// seconds of the day to hour, minute and second, stages 3 to 6
module ecc_time_split
    import ecc_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  logic [16:0] sod,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    logic [29:0] hprod_next, hprod_reg;
    logic [16:0] sod3_reg;
    logic [5:0]  h0;
    logic [16:0] hrem0;
    logic [4:0]  hour_next, hour4_reg, hour5_reg, hour6_reg;
    logic [11:0] rem_next, rem4_reg, rem5_reg;
    logic [22:0] mprod_next, mprod_reg;
    logic [6:0]  m0;
    logic [11:0] mrem0;
    logic [5:0]  minute_next, minute_reg;
    logic [5:0]  second_next, second_reg;

    // stage 3: reciprocal multiply for hours
    assign hprod_next = 30'(sod[16:HOUR_SHIFT]) * 30'(HOUR_RECIP);

    // stage 4: hour with correction, seconds left in the hour
    always_comb
    begin
        h0    = hprod_reg[29:HOUR_RECIP_SHIFT];
        hrem0 = sod3_reg - 17'(h0) * 17'(SECS_PER_HOUR);
        if (hrem0 >= 17'(SECS_PER_HOUR))
        begin
            hour_next = 5'(h0 + 6'd1);
            rem_next  = 12'(hrem0 - 17'(SECS_PER_HOUR));
        end
        else
        begin
            hour_next = 5'(h0);
            rem_next  = 12'(hrem0);
        end
    end

    // stage 5: reciprocal multiply for minutes
    assign mprod_next = 23'(rem4_reg[11:MIN_SHIFT]) * 23'(MIN_RECIP);

    // stage 6: minute with correction, second
    always_comb
    begin
        m0    = mprod_reg[22:MIN_RECIP_SHIFT];
        mrem0 = rem5_reg - 12'(m0) * 12'(SECS_PER_MIN);
        if (mrem0 >= 12'(SECS_PER_MIN))
        begin
            minute_next = 6'(m0 + 7'd1);
            second_next = 6'(mrem0 - 12'(SECS_PER_MIN));
        end
        else
        begin
            minute_next = 6'(m0);
            second_next = 6'(mrem0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            hprod_reg <= hprod_next;
            sod3_reg  <= sod;
        end
        if (en[4])
        begin
            hour4_reg <= hour_next;
            rem4_reg  <= rem_next;
        end
        if (en[5])
        begin
            mprod_reg <= mprod_next;
            rem5_reg  <= rem4_reg;
            hour5_reg <= hour4_reg;
        end
        if (en[6])
        begin
            minute_reg <= minute_next;
            second_reg <= second_next;
            hour6_reg  <= hour5_reg;
        end
    end

    assign hour   = hour6_reg;
    assign minute = minute_reg;
    assign second = second_reg;

endmodule

// ----- rtl/ecc_date_split.sv -----
// day count to year, month and day, stages 3 to 6
module ecc_date_split
    import ecc_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  logic [15:0] days,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day
);

    logic [31:0] yprod_next, yprod_reg;
    logic [15:0] days3_reg, days4_reg;
    logic [7:0]  y0;
    logic [15:0] yrem0;
    logic [6:0]  yi_next, yi4_reg, yi5_reg;
    logic [15:0] cum_here, cum_prev;
    logic [6:0]  yi_sel;
    logic [8:0]  doy_next, doy_reg;
    logic        leap_next, leap_reg;
    logic [3:0]  month_next, month_reg;
    logic [4:0]  day_next, day_reg;
    logic [11:0] year_next, year_reg;

    // stage 3: reciprocal multiply for the year estimate
    assign yprod_next = 32'(days) * 32'(YEAR_RECIP);

    // stage 4: floor of days over 365
    always_comb
    begin
        y0    = yprod_reg[31:YEAR_RECIP_SHIFT];
        yrem0 = days3_reg - 16'(y0) * 16'(DAYS_PER_YEAR);
        if (yrem0 >= 16'(DAYS_PER_YEAR))
        begin
            yi_next = 7'(y0 + 8'd1);
        end
        else
        begin
            yi_next = 7'(y0);
        end
    end

    // stage 5: step back a year when its start lies past the day count
    always_comb
    begin
        cum_here = cum_year(yi4_reg);
        cum_prev = cum_year(yi4_reg - 7'd1);
        if ((cum_here > days4_reg) && (yi4_reg != 7'd0))
        begin
            yi_sel   = yi4_reg - 7'd1;
            doy_next = 9'(days4_reg - cum_prev);
        end
        else
        begin
            yi_sel   = yi4_reg;
            doy_next = 9'(days4_reg - cum_here);
        end
        leap_next = (yi_sel[1:0] == 2'b00);
    end

    // stage 6: month search over the cumulative table, day of month
    always_comb
    begin
        month_next = 4'(MONTHS);
        for (int i = MONTHS - 1; i >= 1; i--)
        begin
            if (doy_reg < cum_month(leap_reg, 4'(i)))
            begin
                month_next = 4'(i);
            end
        end
        day_next  = 5'(doy_reg - cum_month(leap_reg, month_next - 4'd1) + 9'd1);
        year_next = 12'(BASE_YEAR) + 12'(yi5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            yprod_reg <= yprod_next;
            days3_reg <= days;
        end
        if (en[4])
        begin
            yi4_reg   <= yi_next;
            days4_reg <= days3_reg;
        end
        if (en[5])
        begin
            yi5_reg  <= yi_sel;
            doy_reg  <= doy_next;
            leap_reg <= leap_next;
        end
        if (en[6])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;

endmodule

// ----- verif/tb_epoch_seconds_calendar_converter.sv -----
// testbench for the epoch seconds calendar converter: directed table, random words, self-checking
`timescale 1ns / 100ps

module tb_epoch_seconds_calendar_converter;
    import ecc_pkg::*;

    typedef enum bit {
        OP_TO_SECONDS  = 1'b0,
        OP_TO_CALENDAR = 1'b1
    } conv_op_t;

    typedef struct packed {
        conv_op_t    op;
        bit [11:0]   year;
        bit [3:0]    month;
        bit [4:0]    day;
        bit [4:0]    hour;
        bit [5:0]    minute;
        bit [5:0]    second;
        bit [31:0]   elapsed;
    } conv_req_t;

    typedef struct packed {
        bit [31:0]   elapsed;
        bit [11:0]   year;
        bit [3:0]    month;
        bit [4:0]    day;
        bit [4:0]    hour;
        bit [5:0]    minute;
        bit [5:0]    second;
        bit          range_error;
    } conv_rsp_t;

    typedef struct packed {
        conv_req_t   req;
        bit          typed;
        conv_rsp_t   want;
    } dir_row_t;

    localparam int unsigned NUM_DIRECTED  = 25;
    localparam int unsigned NUM_RANDOM    = 1500;
    localparam int unsigned IDLE_PERCENT  = 29;
    localparam int unsigned MAX_PRINTED   = 40;
    localparam int unsigned MONTH_START [13] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

    // results that can be read off at a glance
    localparam conv_rsp_t ZERO_RSP     = '0;
    localparam conv_rsp_t RANGE_RSP    = '{32'd0, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 1'b1};
    localparam conv_rsp_t LAST_SEC_RSP = '{32'd3155759999, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0,
                                           1'b0};
    localparam conv_rsp_t FIRST_CAL_RSP = '{32'd0, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0};
    localparam conv_rsp_t LAST_CAL_RSP  = '{32'd0, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59,
                                            1'b0};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;

    bit          steady = 1'b0;
    int unsigned errors = 0;
    int unsigned words_seen = 0;
    conv_rsp_t   pending_words [$];

    // directed words: field extremes, range errors, ignored fields, leap and month carry
    dir_row_t dir_table [NUM_DIRECTED] = '{
        '{'{OP_TO_SECONDS, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, ZERO_RSP},
        '{'{OP_TO_SECONDS, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd0},
          1'b1, LAST_SEC_RSP},
        '{'{OP_TO_CALENDAR, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, FIRST_CAL_RSP},
        '{'{OP_TO_CALENDAR, 12'hfff, 4'hf, 5'h1f, 5'h1f, 6'h3f, 6'h3f, 32'd3155759999},
          1'b1, LAST_CAL_RSP},
        '{'{OP_TO_CALENDAR, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd3155760000},
          1'b1, RANGE_RSP},
        '{'{OP_TO_CALENDAR, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'hffffffff},
          1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd1999, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'hffffffff},
          1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd2100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'hffffffff},
          1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'hfff, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd2010, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd2010, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd2010, 4'hf, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd2010, 4'd6, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd2010, 4'd6, 5'd5, 5'd24, 6'd0, 6'd0, 32'd0}, 1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd2010, 4'd6, 5'd5, 5'h1f, 6'd0, 6'd0, 32'd0}, 1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd2010, 4'd6, 5'd5, 5'd3, 6'd60, 6'd0, 32'd0}, 1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd2010, 4'd6, 5'd5, 5'd3, 6'h3f, 6'd0, 32'd0}, 1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd2010, 4'd6, 5'd5, 5'd3, 6'd7, 6'd60, 32'd0}, 1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd2010, 4'd6, 5'd5, 5'd3, 6'd7, 6'h3f, 32'd0}, 1'b1, RANGE_RSP},
        '{'{OP_TO_SECONDS, 12'd2001, 4'd2, 5'd31, 5'd12, 6'd0, 6'd0, 32'hffffffff},
          1'b0, ZERO_RSP},
        '{'{OP_TO_SECONDS, 12'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b0, ZERO_RSP},
        '{'{OP_TO_SECONDS, 12'd2000, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd0},
          1'b0, ZERO_RSP},
        '{'{OP_TO_CALENDAR, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd5097600}, 1'b0, ZERO_RSP},
        '{'{OP_TO_CALENDAR, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd31622399}, 1'b0, ZERO_RSP},
        '{'{OP_TO_CALENDAR, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd31622400}, 1'b0, ZERO_RSP}
    };

    epoch_seconds_calendar_converter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // gregorian leap rule
    function automatic bit is_leap(input int unsigned year);
        return ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
    endfunction

    function automatic int unsigned days_before_year(input int unsigned year_idx);
        int unsigned acc;
        acc = 0;
        for (int unsigned i = 0; i < year_idx; i++)
        begin
            acc += is_leap(BASE_YEAR + i) ? 366 : 365;
        end
        return acc;
    endfunction

    function automatic int unsigned days_before_month(input bit leap, input int unsigned idx);
        return MONTH_START[idx] + ((leap && idx >= 2) ? 1 : 0);
    endfunction

    // expected result word for one request word
    function automatic conv_rsp_t convert_calendar(input conv_req_t r);
        conv_rsp_t          o;
        int unsigned        secs;
        int unsigned        days;
        int unsigned        year_idx;
        int unsigned        mon;
        bit                 leap;
        longint unsigned    total;
        o = ZERO_RSP;
        if (r.op == OP_TO_SECONDS)
        begin
            if (r.year < BASE_YEAR || r.year > YEAR_LAST || r.month < 1 || r.month > MONTHS ||
                r.day < 1 || r.hour >= HOURS || r.minute >= MINUTES ||
                r.second >= SECS_PER_MIN)
            begin
                o.range_error = 1'b1;
                return o;
            end
            year_idx = r.year - BASE_YEAR;
            // a day past the end of the month just carries into the next one
            days = days_before_year(year_idx) + days_before_month(is_leap(r.year), r.month - 1)
                   + r.day - 1;
            total = 64'(days) * SECS_PER_DAY + r.hour * SECS_PER_HOUR
                    + r.minute * SECS_PER_MIN + r.second;
            o.elapsed = total[31:0];
        end
        else
        begin
            if (r.elapsed > MAX_ELAPSED)
            begin
                o.range_error = 1'b1;
                return o;
            end
            secs     = r.elapsed % SECS_PER_DAY;
            o.hour   = 5'(secs / SECS_PER_HOUR);
            secs     = secs % SECS_PER_HOUR;
            o.minute = 6'(secs / SECS_PER_MIN);
            o.second = 6'(secs % SECS_PER_MIN);
            // estimate the year from whole days, step back once if it overshoots
            days     = r.elapsed / SECS_PER_DAY;
            year_idx = days / DAYS_PER_YEAR;
            if (year_idx > 100)
                year_idx = 100;
            if (days_before_year(year_idx) > days && year_idx > 0)
                year_idx--;
            days -= days_before_year(year_idx);
            leap = is_leap(BASE_YEAR + year_idx);
            mon  = 1;
            while (mon < MONTHS && days >= days_before_month(leap, mon))
                mon++;
            o.year  = 12'(BASE_YEAR + year_idx);
            o.month = 4'(mon);
            o.day   = 5'(days - days_before_month(leap, mon - 1) + 1);
        end
        return o;
    endfunction

    // random request: mostly legal words, some near month and year starts, the rest noise
    function automatic conv_req_t random_request();
        conv_req_t   r;
        conv_req_t   anchor;
        conv_rsp_t   anchor_rsp;
        bit [95:0]   noise;
        int unsigned pick;
        noise = {$urandom, $urandom, $urandom};
        r     = noise[$bits(conv_req_t)-1:0];
        pick  = $urandom_range(99);
        if (pick < 40)
        begin
            r.op     = OP_TO_SECONDS;
            r.year   = 12'($urandom_range(YEAR_LAST, BASE_YEAR));
            r.month  = 4'($urandom_range(MONTHS, 1));
            r.day    = 5'($urandom_range(31, 1));
            r.hour   = 5'($urandom_range(HOURS - 1, 0));
            r.minute = 6'($urandom_range(MINUTES - 1, 0));
            r.second = 6'($urandom_range(SECS_PER_MIN - 1, 0));
        end
        else if (pick < 75)
        begin
            r.op      = OP_TO_CALENDAR;
            r.elapsed = $urandom_range(MAX_ELAPSED, 0);
        end
        else if (pick < 88)
        begin
            // a couple of seconds around midnight on the first of a month
            anchor        = r;
            anchor.op     = OP_TO_SECONDS;
            anchor.year   = 12'($urandom_range(YEAR_LAST, BASE_YEAR));
            anchor.month  = 4'($urandom_range(MONTHS, 1));
            anchor.day    = 5'd1;
            anchor.hour   = 5'd0;
            anchor.minute = 6'd0;
            anchor.second = 6'd0;
            anchor_rsp    = convert_calendar(anchor);
            r.op          = OP_TO_CALENDAR;
            r.elapsed     = anchor_rsp.elapsed + $urandom_range(4) - 32'd2;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("ERROR at %0t ns, word %0d: %s", $time, words_seen, msg);
    endtask

    // drive one request word and queue what it should produce
    task automatic send_word(input conv_req_t r, input bit typed, input conv_rsp_t want);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, r.elapsed, r.second, r.minute, r.hour, r.day, r.month, r.year};
        s_tuser  <= r.op;
        do
            @(posedge clk);
        while (!s_tready);
        pending_words.push_back(typed ? want : convert_calendar(r));
        @(negedge clk);
    endtask

    // output stall pattern
    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // compare each result word with the oldest pending one
    always @(posedge clk)
    begin : check_output
        conv_rsp_t got;
        conv_rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.elapsed     = m_tdata[31:0];
            got.year        = m_tdata[43:32];
            got.month       = m_tdata[47:44];
            got.day         = m_tdata[52:48];
            got.hour        = m_tdata[57:53];
            got.minute      = m_tdata[63:58];
            got.second      = m_tdata[69:64];
            got.range_error = m_tuser[0];
            if (pending_words.size() == 0)
                report_mismatch("result word with nothing pending");
            else
            begin
                want = pending_words.pop_front();
                if (got.elapsed != want.elapsed)
                    report_mismatch($sformatf("elapsed %0d, want %0d", got.elapsed,
                                              want.elapsed));
                if (got.year != want.year)
                    report_mismatch($sformatf("year %0d, want %0d", got.year, want.year));
                if (got.month != want.month)
                    report_mismatch($sformatf("month %0d, want %0d", got.month, want.month));
                if (got.day != want.day)
                    report_mismatch($sformatf("day %0d, want %0d", got.day, want.day));
                if (got.hour != want.hour)
                    report_mismatch($sformatf("hour %0d, want %0d", got.hour, want.hour));
                if (got.minute != want.minute)
                    report_mismatch($sformatf("minute %0d, want %0d", got.minute,
                                              want.minute));
                if (got.second != want.second)
                    report_mismatch($sformatf("second %0d, want %0d", got.second,
                                              want.second));
                if (got.range_error != want.range_error)
                    report_mismatch($sformatf("range_error %0d, want %0d", got.range_error,
                                              want.range_error));
            end
            words_seen++;
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int unsigned spin;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int unsigned i = 0; i < NUM_DIRECTED; i++)
            send_word(dir_table[i].req, dir_table[i].typed, dir_table[i].want);

        // one long stretch without any idling on either side
        for (int unsigned n = 0; n < NUM_RANDOM; n++)
        begin
            steady = (n >= 600 && n < 900);
            send_word(random_request(), 1'b0, ZERO_RSP);
        end
        steady   = 1'b0;
        s_tvalid <= 1'b0;

        // drain, then give stray words a chance to show up
        spin = 0;
        while (pending_words.size() != 0 && spin < 20000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (4 * NUM_STAGES) @(posedge clk);
        if (pending_words.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", pending_words.size()));

        if (errors == 0)
            $display("PASS epoch_seconds_calendar_converter");
        else
            $display("FAIL epoch_seconds_calendar_converter");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("FAIL epoch_seconds_calendar_converter");
        $finish;
    end

endmodule
